// ===== src/ppcr_pkg.sv =====
// Shared widths, register codes, stage types and helpers of the particle-plane responder.
package ppcr_pkg;

	// Field widths and fraction bits of the Q16.16 format.
	localparam int NW  = 18;
	localparam int DW  = 32;
	localparam int RW  = 17;
	localparam int EW  = 31;
	localparam int FB  = 16;
	localparam int IXW = 3;

	// Derived widths of the datapath.
	localparam int PW  = NW + DW;        // one normal-by-field product
	localparam int SW  = PW + 2;         // sum of three products less the offset
	localparam int QW  = SW - FB;        // dot product floored to Q16.16
	localparam int AW  = PW;             // magnitude of the velocity dot product
	localparam int VW  = 2 * DW;         // sum of velocity squares
	localparam int E2W = 2 * EW;         // epsilon squared
	localparam int KW  = RW + 2;         // one plus the restitution product
	localparam int GPW = QW + KW + 1;    // scaled normal speed before the floor
	localparam int GW  = GPW - FB;       // scaled normal speed
	localparam int MW  = NW + QW;        // normal times a floored dot product
	localparam int NGW = NW + GW;        // normal times the scaled normal speed
	localparam int SCW = QW + 1;         // support scale
	localparam int NSW = NW + SCW;       // normal times the support scale
	localparam int A2W = 2 * AW;         // squared normal speed
	localparam int CW  = E2W + VW;       // epsilon squared times the velocity square
	localparam int XW  = 64;             // working width ahead of saturation

	// Register indexes of the configuration port.
	localparam logic [IXW-1:0] REG_NORMAL_X      = 3'd0;
	localparam logic [IXW-1:0] REG_NORMAL_Y      = 3'd1;
	localparam logic [IXW-1:0] REG_NORMAL_Z      = 3'd2;
	localparam logic [IXW-1:0] REG_PLANE_OFFSET  = 3'd3;
	localparam logic [IXW-1:0] REG_PLANE_REST    = 3'd4;
	localparam logic [IXW-1:0] REG_EPSILON       = 3'd5;
	localparam logic [IXW-1:0] REG_CONTACT_THR   = 3'd6;

	// Reset values of the registers that do not clear to zero, and the constant one in Q16.16.
	localparam logic [NW-1:0] NORMAL_Y_RST = 18'd65536;
	localparam logic [EW-1:0] EPS_RST      = 31'd66;
	localparam logic [EW-1:0] THR_RST      = 31'd6554;
	localparam logic [KW-1:0] ONE_Q16      = 19'd65536;

	typedef logic [2:0][DW-1:0] vec_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

	typedef struct packed {
		logic [2:0][NW-1:0] n;
		logic [DW-1:0]      offset;
		logic [RW-1:0]      prest;
		logic [EW-1:0]      eps;
		logic [EW-1:0]      thr;
	} cfg_t;

	typedef struct packed {
		logic          mode;
		vec_t          pos;
		vec_t          vel;
		vec_t          frc;
		logic [RW-1:0] prest;
	} item_t;

	typedef struct packed {
		logic           mode;
		vec_t           pos;
		vec_t           vel;
		logic [SW-1:0]  sdist;
		logic [SW-1:0]  dv;
		logic [SW-1:0]  df;
		logic [VW-1:0]  vv;
		logic [KW-1:0]  k1;
		logic [E2W-1:0] eps2;
	} s2_t;

	typedef struct packed {
		logic               mode;
		vec_t               pos;
		vec_t               vel;
		logic               dist_lt;
		logic               neg;
		logic               thr_hit;
		logic               df_neg;
		logic [AW-1:0]      adv;
		logic [VW-1:0]      vv;
		logic [E2W-1:0]     eps2;
		logic [2:0][MW-1:0] nd;
		logic [2:0][MW-1:0] ns;
		logic [GPW-1:0]     gp;
		logic [QW-1:0]      f;
	} s3_t;

	typedef struct packed {
		vec_t pos;
		vec_t vel;
		vec_t sup;
		logic responded;
	} result_t;

	// Clamp a wide signed value to the signed 32-bit range.
	function automatic logic [DW-1:0] sat32(input logic signed [XW-1:0] v);
		if (v[XW-1:DW-1] == '0 || v[XW-1:DW-1] == '1) begin
			return v[DW-1:0];
		end else if (v[XW-1]) begin
			return {1'b1, {(DW-1){1'b0}}};
		end else begin
			return {1'b0, {(DW-1){1'b1}}};
		end
	endfunction

endpackage

// ===== src/particle_plane_collision_response_top.sv =====
// Top level of the particle-plane responder: configuration registers, stage control, ports.
//
//   channel   signals                        direction   word
//   input     in_valid / in_ready            in          mode, pos, vel, frc, restitution
//   output    out_valid / out_ready          out         new_pos, new_vel, support, responded
//   config    cfg_write, cfg_index, cfg_data in          one register per write, no wait
//
// Six register stages, s1 to s6, carry each word from the input to the output.
// One word enters per cycle while in_ready is high; the multiplier stages set the depth.
// Each stage advances when it is empty or the stage after it advances, so a stalled
// output fills the empty stages before in_ready drops.
// Reset clears the stage valid bits and loads the register defaults; no clearing pass.
module particle_plane_collision_response_top import ppcr_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_write,
	input  logic [IXW-1:0] cfg_index,
	input  logic [DW-1:0]  cfg_data,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           mode,
	input  logic [DW-1:0]  pos_x,
	input  logic [DW-1:0]  pos_y,
	input  logic [DW-1:0]  pos_z,
	input  logic [DW-1:0]  vel_x,
	input  logic [DW-1:0]  vel_y,
	input  logic [DW-1:0]  vel_z,
	input  logic [DW-1:0]  frc_x,
	input  logic [DW-1:0]  frc_y,
	input  logic [DW-1:0]  frc_z,
	input  logic [RW-1:0]  particle_restitution,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [DW-1:0]  new_pos_x,
	output logic [DW-1:0]  new_pos_y,
	output logic [DW-1:0]  new_pos_z,
	output logic [DW-1:0]  new_vel_x,
	output logic [DW-1:0]  new_vel_y,
	output logic [DW-1:0]  new_vel_z,
	output logic [DW-1:0]  support_x,
	output logic [DW-1:0]  support_y,
	output logic [DW-1:0]  support_z,
	output logic           responded
);

	logic [NW-1:0] normal_x_q;
	logic [NW-1:0] normal_y_q;
	logic [NW-1:0] normal_z_q;
	logic [DW-1:0] offset_q;
	logic [RW-1:0] prest_q;
	logic [EW-1:0] eps_q;
	logic [EW-1:0] thr_q;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic valid_s5;
	logic valid_s6;

	stage_en_t en;
	cfg_t      cfg;
	item_t     item;
	s2_t       s2;
	s3_t       s3;
	logic      gt;
	result_t   res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_x_q <= '0;
			normal_y_q <= NORMAL_Y_RST;
			normal_z_q <= '0;
			offset_q   <= '0;
			prest_q    <= '0;
			eps_q      <= EPS_RST;
			thr_q      <= THR_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_NORMAL_X:     normal_x_q <= cfg_data[NW-1:0];
				REG_NORMAL_Y:     normal_y_q <= cfg_data[NW-1:0];
				REG_NORMAL_Z:     normal_z_q <= cfg_data[NW-1:0];
				REG_PLANE_OFFSET: offset_q   <= cfg_data;
				REG_PLANE_REST:   prest_q    <= cfg_data[RW-1:0];
				REG_EPSILON:      eps_q      <= cfg_data[EW-1:0];
				REG_CONTACT_THR:  thr_q      <= cfg_data[EW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.n[0]   = normal_x_q;
		cfg.n[1]   = normal_y_q;
		cfg.n[2]   = normal_z_q;
		cfg.offset = offset_q;
		cfg.prest  = prest_q;
		cfg.eps    = eps_q;
		cfg.thr    = thr_q;
	end

	// Gather the input word.
	always_comb begin
		item.mode   = mode;
		item.pos    = {pos_z, pos_y, pos_x};
		item.vel    = {vel_z, vel_y, vel_x};
		item.frc    = {frc_z, frc_y, frc_x};
		item.prest  = particle_restitution;
	end

	// Stage enables: a stage moves when it is empty or its successor moves.
	always_comb begin
		en.s6 = ~valid_s6 | out_ready;
		en.s5 = ~valid_s5 | en.s6;
		en.s4 = ~valid_s4 | en.s5;
		en.s3 = ~valid_s3 | en.s4;
		en.s2 = ~valid_s2 | en.s3;
		en.s1 = ~valid_s1 | en.s2;
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= in_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
			if (en.s6) valid_s6 <= valid_s5;
		end
	end

	ppcr_front u_front (
		.clk  (clk),
		.en   (en),
		.cfg  (cfg),
		.item (item),
		.s2   (s2)
	);

	ppcr_cond u_cond (
		.clk (clk),
		.en  (en),
		.cfg (cfg),
		.s2  (s2),
		.s3  (s3)
	);

	ppcr_sqcmp u_sqcmp (
		.clk  (clk),
		.en   (en),
		.adv  (s3.adv),
		.vv   (s3.vv),
		.eps2 (s3.eps2),
		.gt   (gt)
	);

	ppcr_update u_update (
		.clk (clk),
		.en  (en),
		.cfg (cfg),
		.s3  (s3),
		.gt  (gt),
		.res (res)
	);

	assign in_ready  = en.s1;
	assign out_valid = valid_s6;
	assign new_pos_x = res.pos[0];
	assign new_pos_y = res.pos[1];
	assign new_pos_z = res.pos[2];
	assign new_vel_x = res.vel[0];
	assign new_vel_y = res.vel[1];
	assign new_vel_z = res.vel[2];
	assign support_x = res.sup[0];
	assign support_y = res.sup[1];
	assign support_z = res.sup[2];
	assign responded = res.responded;

`ifndef SYNTHESIS
	// Input stalls only when every stage holds a word.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && valid_s6))
		else $error("input stalled with an empty stage");

	// Without a transfer on either side the number of words in flight holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!(in_valid && in_ready) && !(out_valid && out_ready)) |=>
		($countones({valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6}) ==
		$past($countones({valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6}))))
		else $error("word lost or duplicated in the pipeline");

	// A word without a response carries no support force.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !responded) |->
		(support_x == '0 && support_y == '0 && support_z == '0))
		else $error("support force without a response");
`endif

endmodule

// ===== src/ppcr_front.sv =====
// Front stages: normal products, squares, restitution product, then the three dot sums.
module ppcr_front import ppcr_pkg::*; (
	input  logic      clk,
	input  stage_en_t en,
	input  cfg_t      cfg,
	input  item_t     item,
	output s2_t       s2
);

	localparam int KPW = 2 * RW;

	logic                mode_s1;
	vec_t                pos_s1;
	vec_t                vel_s1;
	logic [2:0][PW-1:0]  px_s1;
	logic [2:0][PW-1:0]  pv_s1;
	logic [2:0][PW-1:0]  pf_s1;
	logic [2:0][VW-2:0]  vsq_s1;
	logic [RW:0]         k_s1;
	logic [E2W-1:0]      eps2_s1;

	logic [2:0][PW-1:0]  px;
	logic [2:0][PW-1:0]  pv;
	logic [2:0][PW-1:0]  pf;
	logic [2:0][VW-2:0]  vsq;
	logic [KPW-1:0]      kprod;
	logic [E2W-1:0]      eps2;
	s2_t                 s2_nxt;

	// Stage 1: every multiplication on the incoming word.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			px[i]  = PW'($signed(cfg.n[i])) * PW'($signed(item.pos[i]));
			pv[i]  = PW'($signed(cfg.n[i])) * PW'($signed(item.vel[i]));
			pf[i]  = PW'($signed(cfg.n[i])) * PW'($signed(item.frc[i]));
			vsq[i] = (VW-1)'(VW'($signed(item.vel[i])) * VW'($signed(item.vel[i])));
		end
		kprod = KPW'(cfg.prest) * KPW'(item.prest);
		eps2  = E2W'(cfg.eps) * E2W'(cfg.eps);
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			mode_s1 <= item.mode;
			pos_s1  <= item.pos;
			vel_s1  <= item.vel;
			px_s1   <= px;
			pv_s1   <= pv;
			pf_s1   <= pf;
			vsq_s1  <= vsq;
			k_s1    <= kprod[KPW-1:FB];
			eps2_s1 <= eps2;
		end
	end

	// Stage 2: dot sums, distance and the velocity square sum.
	always_comb begin
		s2_nxt.mode  = mode_s1;
		s2_nxt.pos   = pos_s1;
		s2_nxt.vel   = vel_s1;
		s2_nxt.sdist = SW'($signed(px_s1[0])) + SW'($signed(px_s1[1]))
			+ SW'($signed(px_s1[2])) - SW'($signed({cfg.offset, {FB{1'b0}}}));
		s2_nxt.dv    = SW'($signed(pv_s1[0])) + SW'($signed(pv_s1[1]))
			+ SW'($signed(pv_s1[2]));
		s2_nxt.df    = SW'($signed(pf_s1[0])) + SW'($signed(pf_s1[1]))
			+ SW'($signed(pf_s1[2]));
		s2_nxt.vv    = VW'(vsq_s1[0]) + VW'(vsq_s1[1]) + VW'(vsq_s1[2]);
		s2_nxt.k1    = KW'(k_s1) + ONE_Q16;
		s2_nxt.eps2  = eps2_s1;
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			s2 <= s2_nxt;
		end
	end

endmodule

// ===== src/ppcr_cond.sv =====
// Stage 3: distance and speed tests, normal speed magnitude and the first response products.
module ppcr_cond import ppcr_pkg::*; (
	input  logic      clk,
	input  stage_en_t en,
	input  cfg_t      cfg,
	input  s2_t       s2,
	output s3_t       s3
);

	logic [SW-1:0] absd;
	s3_t           s3_nxt;

	// Tests compare exact dot products; products use the floored Q16.16 values.
	always_comb begin
		s3_nxt.mode    = s2.mode;
		s3_nxt.pos     = s2.pos;
		s3_nxt.vel     = s2.vel;
		s3_nxt.dist_lt = $signed(s2.sdist) < SW'($signed({1'b0, cfg.eps, {FB{1'b0}}}));
		s3_nxt.neg     = s2.dv[SW-1];
		absd           = s2.dv[SW-1] ? (SW'(0) - s2.dv) : s2.dv;
		s3_nxt.adv     = absd[AW-1:0];
		s3_nxt.thr_hit = absd[AW-1:0] < AW'({cfg.thr, {FB{1'b0}}});
		s3_nxt.df_neg  = s2.df[SW-1];
		s3_nxt.vv      = s2.vv;
		s3_nxt.eps2    = s2.eps2;
		for (int i = 0; i < 3; i++) begin
			s3_nxt.nd[i] = MW'($signed(cfg.n[i])) * MW'($signed(s2.sdist[SW-1:FB]));
			s3_nxt.ns[i] = MW'($signed(cfg.n[i])) * MW'($signed(s2.dv[SW-1:FB]));
		end
		s3_nxt.gp = GPW'($signed(s2.dv[SW-1:FB])) * GPW'($signed({1'b0, s2.k1}));
		s3_nxt.f  = s2.df[SW-1:FB];
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			s3 <= s3_nxt;
		end
	end

endmodule

// ===== src/ppcr_sqcmp.sv =====
// Approach test: squared normal speed against epsilon squared times speed squared.
module ppcr_sqcmp import ppcr_pkg::*; (
	input  logic           clk,
	input  stage_en_t      en,
	input  logic [AW-1:0]  adv,
	input  logic [VW-1:0]  vv,
	input  logic [E2W-1:0] eps2,
	output logic           gt
);

	localparam int AH  = AW / 2;
	localparam int HW  = DW;
	localparam int LLW = 2 * AH;
	localparam int HHW = 2 * (AW - AH);
	localparam int E1W = E2W - HW;
	localparam int V1W = VW - HW;

	logic [LLW-1:0]     pll_s4;
	logic [AW-1:0]      plh_s4;
	logic [HHW-1:0]     phh_s4;
	logic [2*HW-1:0]    q00_s4;
	logic [HW+V1W-1:0]  q01_s4;
	logic [E1W+HW-1:0]  q10_s4;
	logic [E1W+V1W-1:0] q11_s4;
	logic [A2W-1:0]     a2_s5;
	logic [CW-1:0]      e2_s5;

	// Stage 4: partial products, none wider than 32 by 32.
	always_ff @(posedge clk) begin
		if (en.s4) begin
			pll_s4 <= LLW'(adv[AH-1:0]) * LLW'(adv[AH-1:0]);
			plh_s4 <= AW'(adv[AH-1:0]) * AW'(adv[AW-1:AH]);
			phh_s4 <= HHW'(adv[AW-1:AH]) * HHW'(adv[AW-1:AH]);
			q00_s4 <= (2*HW)'(eps2[HW-1:0]) * (2*HW)'(vv[HW-1:0]);
			q01_s4 <= (HW+V1W)'(eps2[HW-1:0]) * (HW+V1W)'(vv[VW-1:HW]);
			q10_s4 <= (E1W+HW)'(eps2[E2W-1:HW]) * (E1W+HW)'(vv[HW-1:0]);
			q11_s4 <= (E1W+V1W)'(eps2[E2W-1:HW]) * (E1W+V1W)'(vv[VW-1:HW]);
		end
	end

	// Stage 5: assemble both full products.
	always_ff @(posedge clk) begin
		if (en.s5) begin
			a2_s5 <= A2W'(pll_s4) + (A2W'(plh_s4) << (AH + 1)) + (A2W'(phh_s4) << (2 * AH));
			e2_s5 <= CW'(q00_s4) + (CW'(q01_s4) << HW) + (CW'(q10_s4) << HW)
				+ (CW'(q11_s4) << (2 * HW));
		end
	end

	assign gt = CW'(a2_s5) > e2_s5;

endmodule

// ===== src/ppcr_update.sv =====
// Stages 4 to 6: new position, both velocity candidates, support force and the final select.
module ppcr_update import ppcr_pkg::*; (
	input  logic      clk,
	input  stage_en_t en,
	input  cfg_t      cfg,
	input  s3_t       s3,
	input  logic      gt,
	output result_t   res
);

	logic                mode_s4;
	vec_t                pos_s4;
	vec_t                vel_s4;
	logic                dist_lt_s4;
	logic                neg_s4;
	logic                thr_hit_s4;
	vec_t                npos_s4;
	vec_t                velc_s4;
	logic [2:0][NGW-1:0] ng_s4;
	logic [2:0][NSW-1:0] nsc_s4;

	logic                mode_s5;
	vec_t                pos_s5;
	vec_t                vel_s5;
	logic                dist_lt_s5;
	logic                neg_s5;
	logic                thr_hit_s5;
	vec_t                npos_s5;
	vec_t                velc_s5;
	vec_t                velg_s5;
	vec_t                sup_s5;

	result_t             res_s6;

	logic signed [GW-1:0]  g;
	logic signed [SCW-1:0] scale;
	logic [2:0][NGW-1:0]   ng;
	logic [2:0][NSW-1:0]   nsc;
	vec_t                  npos;
	vec_t                  velc;
	vec_t                  velg;
	vec_t                  sup;
	logic                  hit_col;
	logic                  hit_con;
	result_t               res_nxt;

	// Stage 4: projected position, contact velocity, and the products for stage 5.
	always_comb begin
		g     = $signed(s3.gp[GPW-1:FB]);
		scale = s3.df_neg ? (SCW'(0) - SCW'($signed(s3.f))) : '0;
		for (int i = 0; i < 3; i++) begin
			ng[i]   = NGW'($signed(cfg.n[i])) * NGW'(g);
			nsc[i]  = NSW'($signed(cfg.n[i])) * NSW'(scale);
			npos[i] = sat32(XW'($signed(s3.pos[i])) - XW'($signed(s3.nd[i][MW-1:FB])));
			velc[i] = sat32(XW'($signed(s3.vel[i])) - XW'($signed(s3.ns[i][MW-1:FB])));
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			mode_s4    <= s3.mode;
			pos_s4     <= s3.pos;
			vel_s4     <= s3.vel;
			dist_lt_s4 <= s3.dist_lt;
			neg_s4     <= s3.neg;
			thr_hit_s4 <= s3.thr_hit;
			npos_s4    <= npos;
			velc_s4    <= velc;
			ng_s4      <= ng;
			nsc_s4     <= nsc;
		end
	end

	// Stage 5: reflected velocity and support force.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			velg[i] = sat32(XW'($signed(vel_s4[i])) - XW'($signed(ng_s4[i][NGW-1:FB])));
			sup[i]  = sat32(XW'($signed(nsc_s4[i][NSW-1:FB])));
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			mode_s5    <= mode_s4;
			pos_s5     <= pos_s4;
			vel_s5     <= vel_s4;
			dist_lt_s5 <= dist_lt_s4;
			neg_s5     <= neg_s4;
			thr_hit_s5 <= thr_hit_s4;
			npos_s5    <= npos_s4;
			velc_s5    <= velc_s4;
			velg_s5    <= velg;
			sup_s5     <= sup;
		end
	end

	// Stage 6: decide the response and pick the result word.
	always_comb begin
		hit_col = dist_lt_s5 & ~mode_s5 & neg_s5 & gt;
		hit_con = dist_lt_s5 & mode_s5 & thr_hit_s5;
		res_nxt.responded = hit_col | hit_con;
		res_nxt.pos = (hit_col | hit_con) ? npos_s5 : pos_s5;
		priority if (hit_col) begin
			res_nxt.vel = velg_s5;
		end else if (hit_con) begin
			res_nxt.vel = velc_s5;
		end else begin
			res_nxt.vel = vel_s5;
		end
		res_nxt.sup = hit_con ? sup_s5 : '0;
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			res_s6 <= res_nxt;
		end
	end

	assign res = res_s6;

endmodule

// ===== tb/tb_particle_plane_collision_response_top.sv =====
// Self-checking testbench of the particle-plane collision and contact responder.
module tb_particle_plane_collision_response_top;
	import ppcr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ONE = 65536;
	localparam int MIN_Q = 32'h8000_0000;
	localparam int MAX_Q = 32'h7fff_ffff;
	localparam int SETTINGS_RUN = 8;
	localparam int RANDOM_PER_SETTING = 219;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT = 400000;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           cfg_write = 1'b0;
	logic [IXW-1:0] cfg_index = '0;
	logic [DW-1:0]  cfg_data = '0;
	logic           in_valid = 1'b0;
	logic           in_ready;
	logic           mode = 1'b0;
	logic [DW-1:0]  pos_x = '0;
	logic [DW-1:0]  pos_y = '0;
	logic [DW-1:0]  pos_z = '0;
	logic [DW-1:0]  vel_x = '0;
	logic [DW-1:0]  vel_y = '0;
	logic [DW-1:0]  vel_z = '0;
	logic [DW-1:0]  frc_x = '0;
	logic [DW-1:0]  frc_y = '0;
	logic [DW-1:0]  frc_z = '0;
	logic [RW-1:0]  particle_restitution = '0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	logic [DW-1:0]  new_pos_x;
	logic [DW-1:0]  new_pos_y;
	logic [DW-1:0]  new_pos_z;
	logic [DW-1:0]  new_vel_x;
	logic [DW-1:0]  new_vel_y;
	logic [DW-1:0]  new_vel_z;
	logic [DW-1:0]  support_x;
	logic [DW-1:0]  support_y;
	logic [DW-1:0]  support_z;
	logic           responded;

	// Shadow copy of the plane registers, starting from their reset values.
	cfg_t plane_cfg = '{n: '{18'd0, NORMAL_Y_RST, 18'd0}, offset: '0, prest: '0,
		eps: EPS_RST, thr: THR_RST};

	item_t   particle_q[$];
	result_t response_q[$];
	item_t   cur_word;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	int      mismatch_count = 0;
	int      cycle_count = 0;
	string   axis_tag[3] = '{"x", "y", "z"};

	particle_plane_collision_response_top DUT (.*);

	// Free-running clock, 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Clamp a wide signed value into the Q16.16 range.
	function automatic logic [DW-1:0] clamp_q16(input longint v);
		if (v > longint'(MAX_Q)) begin
			return MAX_Q;
		end else if (v < longint'(MIN_Q)) begin
			return MIN_Q;
		end
		return v[DW-1:0];
	endfunction

	// Expected response of one particle against the plane held in c.
	function automatic result_t predict_response(input cfg_t c, input item_t w);
		result_t     r;
		longint      n[3], x[3], v[3], f[3];
		longint      sdist, dv, df, dq, sq, gq, k, scale, speed;
		logic [63:0] adv, vv, e2;
		logic [127:0] lhs, rhs;
		bit          hit;
		for (int i = 0; i < 3; i++) begin
			n[i] = $signed(c.n[i]);
			x[i] = $signed(w.pos[i]);
			v[i] = $signed(w.vel[i]);
			f[i] = $signed(w.frc[i]);
		end
		sdist = n[0] * x[0] + n[1] * x[1] + n[2] * x[2] - longint'($signed(c.offset)) * ONE;
		dv = n[0] * v[0] + n[1] * v[1] + n[2] * v[2];
		df = n[0] * f[0] + n[1] * f[1] + n[2] * f[2];
		dq = sdist >>> FB;
		sq = dv >>> FB;
		hit = 1'b0;
		r.pos = w.pos;
		r.vel = w.vel;
		r.sup = '0;
		if (sdist < longint'(c.eps) * ONE) begin
			if (!w.mode) begin
				// Approach test on squares: (N.v)^2 against eps^2 * |v|^2.
				if (dv < 0) begin
					adv = -dv;
					vv = '0;
					for (int i = 0; i < 3; i++) begin
						vv += 64'(v[i] * v[i]);
					end
					e2 = longint'(c.eps) * longint'(c.eps);
					lhs = {64'd0, adv} * {64'd0, adv};
					rhs = {64'd0, e2} * {64'd0, vv};
					hit = lhs > rhs;
				end
				if (hit) begin
					k = (longint'(c.prest) * longint'(w.prest)) >>> FB;
					gq = (sq * (ONE + k)) >>> FB;
					for (int i = 0; i < 3; i++) begin
						r.vel[i] = clamp_q16(v[i] - ((n[i] * gq) >>> FB));
					end
				end
			end else begin
				// Resting contact: normal speed below the threshold.
				speed = (dv < 0) ? -dv : dv;
				hit = speed < longint'(c.thr) * ONE;
				if (hit) begin
					for (int i = 0; i < 3; i++) begin
						r.vel[i] = clamp_q16(v[i] - ((n[i] * sq) >>> FB));
					end
					if (df < 0) begin
						scale = -(df >>> FB);
						for (int i = 0; i < 3; i++) begin
							r.sup[i] = clamp_q16((n[i] * scale) >>> FB);
						end
					end
				end
			end
			if (hit) begin
				for (int i = 0; i < 3; i++) begin
					r.pos[i] = clamp_q16(x[i] - ((n[i] * dq) >>> FB));
				end
			end
		end
		r.responded = hit;
		return r;
	endfunction

	// Random Q16.16 value, mixing full range, small, tiny, extreme and zero values.
	function automatic logic [DW-1:0] rand_q16();
		logic [DW-1:0] v;
		case ($urandom_range(0, 5))
			0, 1: v = $urandom;
			2: v = $urandom_range(0, 2097152) - 1048576;
			3: v = $urandom_range(0, 8192) - 4096;
			4: begin
				case ($urandom_range(0, 3))
					0: v = MIN_Q;
					1: v = MAX_Q;
					2: v = '1;
					default: v = ONE;
				endcase
			end
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic item_t make_word(input bit m, input int px, input int py, input int pz,
			input int vx, input int vy, input int vz, input int fx, input int fy, input int fz,
			input int rest);
		item_t w;
		w.mode = m;
		w.pos = '{pz, py, px};
		w.vel = '{vz, vy, vx};
		w.frc = '{fz, fy, fx};
		w.prest = RW'(rest);
		return w;
	endfunction

	function automatic item_t random_word();
		item_t w;
		w.mode = 1'($urandom_range(0, 1));
		for (int i = 0; i < 3; i++) begin
			w.pos[i] = rand_q16();
			w.vel[i] = rand_q16();
			w.frc[i] = rand_q16();
		end
		// Slow particles give the resting-contact test a fair chance to pass.
		if ($urandom_range(0, 2) == 0) begin
			for (int i = 0; i < 3; i++) begin
				w.vel[i] = $urandom_range(0, 2048) - 1024;
			end
		end
		if ($urandom_range(0, 4) == 0) begin
			w.prest = RW'($urandom_range(0, 131071));
		end else begin
			w.prest = RW'($urandom_range(0, ONE));
		end
		return w;
	endfunction

	// Directed words under the reset plane: y-up normal, zero offset.
	task automatic queue_directed();
		particle_q.push_back(make_word(0, 0, -ONE, 0, 0, -2 * ONE, 0, 0, 0, 0, ONE));
		particle_q.push_back(make_word(0, 0, -ONE, 0, 0, 0, 0, 0, 0, 0, ONE));
		particle_q.push_back(make_word(0, 0, -ONE, 0, 0, ONE, 0, 0, 0, 0, ONE));
		particle_q.push_back(make_word(0, 0, 5 * ONE, 0, 0, -ONE, 0, 0, 0, 0, ONE));
		particle_q.push_back(make_word(0, 0, -ONE, 0, MAX_Q, -1, 0, 0, 0, 0, ONE));
		particle_q.push_back(make_word(0, 0, 66, 0, 0, -ONE, 0, 0, 0, 0, ONE));
		particle_q.push_back(make_word(0, 0, 65, 0, 3, -ONE, 0, 0, 0, 0, 32768));
		particle_q.push_back(make_word(1, 7, -256, 9, 0, 256, 0, 4660, -5 * ONE, 0, 0));
		particle_q.push_back(make_word(1, 7, -256, 9, 0, 256, 0, 4660, 3 * ONE, 0, 0));
		particle_q.push_back(make_word(1, 0, -ONE, 0, 0, 6554, 0, 0, -ONE, 0, 0));
		particle_q.push_back(make_word(1, 0, -ONE, 0, 0, -6553, 0, 0, -ONE, 0, 0));
		particle_q.push_back(make_word(1, 0, 0, 0, 0, 2 * ONE, 0, 0, -ONE, 0, 0));
		particle_q.push_back(make_word(0, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q,
			MIN_Q, MIN_Q, MIN_Q, 0));
		particle_q.push_back(make_word(1, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q,
			MIN_Q, MIN_Q, MIN_Q, 131071));
		particle_q.push_back(make_word(0, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q,
			MAX_Q, MAX_Q, MAX_Q, 131071));
		particle_q.push_back(make_word(1, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q,
			MAX_Q, MAX_Q, MAX_Q, ONE));
		particle_q.push_back(make_word(0, -1, -1, -1, -1, -1, -1, -1, -1, -1, 131071));
		particle_q.push_back(make_word(1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 131071));
		particle_q.push_back(make_word(1, 0, -2 * ONE, 0, 0, 0, 0, MIN_Q, MIN_Q, MIN_Q, 0));
		particle_q.push_back(make_word(0, 0, MIN_Q, 0, 0, MIN_Q, 0, 0, 0, 0, ONE));
	endtask

	// One register write, mirrored into the shadow copy.
	task automatic write_reg(input logic [IXW-1:0] idx, input logic [DW-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_NORMAL_X: plane_cfg.n[0] = val[NW-1:0];
			REG_NORMAL_Y: plane_cfg.n[1] = val[NW-1:0];
			REG_NORMAL_Z: plane_cfg.n[2] = val[NW-1:0];
			REG_PLANE_OFFSET: plane_cfg.offset = val;
			REG_PLANE_REST: plane_cfg.prest = val[RW-1:0];
			REG_EPSILON: plane_cfg.eps = val[EW-1:0];
			REG_CONTACT_THR: plane_cfg.thr = val[EW-1:0];
			default: ;
		endcase
	endtask

	// Load a plane setting: fixed extremes first, then random planes.
	task automatic apply_setting(input int sel);
		int v[7];
		case (sel)
			1: v = '{0, 0, ONE, ONE, ONE, 0, 0};
			2: v = '{-ONE, 0, 0, MIN_Q, 0, MAX_Q, MAX_Q};
			3: v = '{37837, 37837, 37837, MAX_Q, 49152, 655, ONE};
			4: v = '{46341, -46341, 0, -2 * ONE, ONE, 66, 6554};
			default: begin
				for (int i = 0; i < 3; i++) begin
					v[i] = $urandom_range(0, 2 * ONE) - ONE;
				end
				v[3] = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 8 * ONE) - 4 * ONE
					: rand_q16();
				v[4] = $urandom_range(0, ONE);
				v[5] = ($urandom_range(0, 1) == 0) ? $urandom_range(0, ONE)
					: $urandom_range(0, MAX_Q);
				v[6] = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4 * ONE)
					: $urandom_range(0, MAX_Q);
			end
		endcase
		write_reg(REG_NORMAL_X, v[0]);
		write_reg(REG_NORMAL_Y, v[1]);
		write_reg(REG_NORMAL_Z, v[2]);
		write_reg(REG_PLANE_OFFSET, v[3]);
		write_reg(REG_PLANE_REST, v[4]);
		write_reg(REG_EPSILON, v[5]);
		write_reg(REG_CONTACT_THR, v[6]);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic check_word(input result_t got, input result_t want);
		for (int i = 0; i < 3; i++) begin
			if (got.pos[i] !== want.pos[i]) begin
				$error("new_pos_%s: expected %h, got %h", axis_tag[i], want.pos[i], got.pos[i]);
				mismatch_count++;
			end
			if (got.vel[i] !== want.vel[i]) begin
				$error("new_vel_%s: expected %h, got %h", axis_tag[i], want.vel[i], got.vel[i]);
				mismatch_count++;
			end
			if (got.sup[i] !== want.sup[i]) begin
				$error("support_%s: expected %h, got %h", axis_tag[i], want.sup[i], got.sup[i]);
				mismatch_count++;
			end
		end
		if (got.responded !== want.responded) begin
			$error("responded: expected %b, got %b", want.responded, got.responded);
			mismatch_count++;
		end
	endtask

	// Input driver: predicts each accepted word, then offers the next one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				response_q.push_back(predict_response(plane_cfg, cur_word));
			end
			if (!in_valid || in_ready) begin
				if (particle_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cur_word = particle_q.pop_front();
					in_valid <= 1'b1;
					mode <= cur_word.mode;
					pos_x <= cur_word.pos[0];
					pos_y <= cur_word.pos[1];
					pos_z <= cur_word.pos[2];
					vel_x <= cur_word.vel[0];
					vel_y <= cur_word.vel[1];
					vel_z <= cur_word.vel[2];
					frc_x <= cur_word.frc[0];
					frc_y <= cur_word.frc[1];
					frc_z <= cur_word.frc[2];
					particle_restitution <= cur_word.prest;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: random back-pressure and in-order comparison.
	always @(posedge clk) begin : monitor
		result_t got;
		if (arst_n) begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			if (out_valid && out_ready) begin
				got.pos[0] = new_pos_x;
				got.pos[1] = new_pos_y;
				got.pos[2] = new_pos_z;
				got.vel[0] = new_vel_x;
				got.vel[1] = new_vel_y;
				got.vel[2] = new_vel_z;
				got.sup[0] = support_x;
				got.sup[1] = support_y;
				got.sup[2] = support_z;
				got.responded = responded;
				if (response_q.size() == 0) begin
					$error("result word with no expected response pending");
					mismatch_count++;
				end else begin
					check_word(got, response_q.pop_front());
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Sequence of plane settings, each with one of four idling patterns.
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < SETTINGS_RUN; phase++) begin
			// Registers change only once every word of the last setting is back.
			@(negedge clk);
			while (particle_q.size() != 0 || in_valid || response_q.size() != 0) begin
				@(negedge clk);
			end
			if (phase > 0) begin
				apply_setting(phase);
			end
			@(negedge clk);
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 75;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 75;
				end
				default: begin
					send_idle_pct = 26;
					recv_stall_pct = 26;
				end
			endcase
			if (phase == 0) begin
				queue_directed();
			end
			for (int i = 0; i < RANDOM_PER_SETTING; i++) begin
				particle_q.push_back(random_word());
			end
		end
		@(negedge clk);
		while (particle_q.size() != 0 || in_valid || response_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
